// ===== hw/rtl/lzrw_pkg.sv =====
// lzrw_pkg: shared constants and types for the lzss ring window decoder
// no dependencies; imported by lzrw_window, lzrw_ctrl and the top level
`timescale 1ns / 1ps

package lzrw_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int POS_W       = $clog2(WINDOW_SIZE);
  localparam int FILL_W      = POS_W + 1;
  localparam int COUNT_BITS  = 24;
  localparam int BYTES_OUT_W = 24;
  localparam int EXP_W       = 24;
  localparam int REM_W       = 5;

  localparam logic [POS_W-1:0] START_POS = POS_W'(12'hFEE);
  localparam logic [REM_W-1:0] LEN_BIAS  = REM_W'(3);
  localparam logic [3:0]       CHUNK_FLAG = 4'd8;

  // configuration port
  localparam int  CFG_ADDR_W = 3;
  localparam int  CFG_DATA_W = 32;
  localparam logic REG_EXPECTED_SIZE = 1'b0;

  // window memory request
  typedef struct packed {
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             restart;
  } win_req_t;

  // one result
  typedef struct packed {
    logic                   byte_valid;
    logic [7:0]             out_byte;
    logic                   run_last;
    logic                   stream_end;
    logic [BYTES_OUT_W-1:0] bytes_out;
  } out_row_t;

endpackage

// ===== hw/rtl/lzrw_window.sv =====
// lzrw_window: 4 KiB history ring in a synchronous ram with registered read data
// depends on lzrw_pkg; entries outside the fill range read as zero
`timescale 1ns / 1ps

module lzrw_window
  import lzrw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  win_req_t req,
  output logic [7:0] rd_data
);

  logic [7:0]        mem [WINDOW_SIZE];
  logic [7:0]        mem_q_r;
  logic              hit_r;
  logic              hit_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [POS_W-1:0]  offset;

  // writes run in order from the start position, so written entries form
  // one contiguous arc of length fill_r
  assign offset  = req.rd_addr - START_POS;
  assign hit_nxt = {1'b0, offset} < fill_r;

  always_comb begin
    fill_nxt = fill_r;
    if (req.restart) begin
      fill_nxt = '0;
    end else if (req.wr_en && fill_r != FILL_W'(WINDOW_SIZE)) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      hit_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (req.rd_en) begin
        hit_r <= hit_nxt;
      end
    end
  end

  assign rd_data = hit_r ? mem_q_r : 8'd0;

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.rd_en && req.wr_en))
    else $error("window read and write in the same cycle");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_SIZE))
    else $error("fill count beyond window size");

  a_restart_empties: assert property (@(posedge clk) disable iff (!rst_n)
    req.restart |=> fill_r == '0)
    else $error("restart did not empty the window");

endmodule

// ===== hw/rtl/lzrw_ctrl.sv =====
// lzrw_ctrl: token parser, copy sequencer and output register
// depends on lzrw_pkg; drives the window memory requests of lzrw_window
`timescale 1ns / 1ps

module lzrw_ctrl
  import lzrw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [EXP_W-1:0] expected_size,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_tready,
  output out_row_t         out_row,
  output win_req_t         win_req,
  input  logic [7:0]       win_rd_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LIT  = 5'b00010,
    S_RD   = 5'b00100,
    S_WR   = 5'b01000,
    S_END  = 5'b10000
  } state_t;

  localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

  state_t                state_r, state_nxt;
  logic [7:0]            flag_r, flag_nxt;
  logic [3:0]            chunk_r, chunk_nxt;
  logic [7:0]            held_r, held_nxt;
  logic                  have_r, have_nxt;
  logic                  last_r, last_nxt;
  logic [7:0]            lit_r, lit_nxt;
  logic [POS_W-1:0]      rpos_r, rpos_nxt;
  logic [POS_W-1:0]      wpos_r, wpos_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_row_t              out_row_r, out_row_nxt;

  logic                  out_free;
  logic                  out_load;
  logic [31:0]           exp_wide;
  logic [COUNT_BITS-1:0] limit;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  active;
  logic                  copy_done;

  assign out_free  = !out_valid_r || out_tready;
  assign exp_wide  = 32'(expected_size);
  assign limit     = (exp_wide > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX)
                                            : COUNT_BITS'(exp_wide);
  assign count_inc = count_r + 1'b1;
  assign active    = count_r < limit;
  assign copy_done = (rem_r == REM_W'(1)) || (count_inc == limit);

  always_comb begin
    state_nxt   = state_r;
    flag_nxt    = flag_r;
    chunk_nxt   = chunk_r;
    held_nxt    = held_r;
    have_nxt    = have_r;
    last_nxt    = last_r;
    lit_nxt     = lit_r;
    rpos_nxt    = rpos_r;
    wpos_nxt    = wpos_r;
    rem_nxt     = rem_r;
    count_nxt   = count_r;
    out_load    = 1'b0;
    out_row_nxt = out_row_r;
    win_req     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          last_nxt  = in_last;
          state_nxt = in_last ? S_END : S_IDLE;
          if (active) begin
            priority if (chunk_r[3]) begin
              flag_nxt  = in_byte;
              chunk_nxt = '0;
            end else if (flag_r[chunk_r[2:0]]) begin
              lit_nxt   = in_byte;
              chunk_nxt = chunk_r + 1'b1;
              state_nxt = S_LIT;
            end else if (!have_r) begin
              held_nxt = in_byte;
              have_nxt = 1'b1;
            end else begin
              have_nxt  = 1'b0;
              chunk_nxt = chunk_r + 1'b1;
              rpos_nxt  = {in_byte[7:4], held_r};
              rem_nxt   = REM_W'(in_byte[3:0]) + LEN_BIAS;
              state_nxt = S_RD;
            end
          end
        end
      end
      S_LIT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_row_nxt     = '{1'b1, lit_r, !last_r, 1'b0, BYTES_OUT_W'(count_inc)};
          win_req.wr_en   = 1'b1;
          win_req.wr_addr = wpos_r;
          win_req.wr_data = lit_r;
          wpos_nxt        = wpos_r + 1'b1;
          count_nxt       = count_inc;
          state_nxt       = last_r ? S_END : S_IDLE;
        end
      end
      S_RD: begin
        win_req.rd_en   = 1'b1;
        win_req.rd_addr = rpos_r;
        rpos_nxt        = rpos_r + 1'b1;
        state_nxt       = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_row_nxt     = '{1'b1, win_rd_data, !last_r && copy_done, 1'b0,
                              BYTES_OUT_W'(count_inc)};
          win_req.wr_en   = 1'b1;
          win_req.wr_addr = wpos_r;
          win_req.wr_data = win_rd_data;
          wpos_nxt        = wpos_r + 1'b1;
          count_nxt       = count_inc;
          rem_nxt         = rem_r - 1'b1;
          if (copy_done) begin
            state_nxt = last_r ? S_END : S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_row_nxt     = '{1'b0, 8'd0, 1'b1, 1'b1, BYTES_OUT_W'(count_r)};
          win_req.restart = 1'b1;
          wpos_nxt        = START_POS;
          flag_nxt        = '0;
          chunk_nxt       = CHUNK_FLAG;
          held_nxt        = '0;
          have_nxt        = 1'b0;
          count_nxt       = '0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flag_r      <= '0;
      chunk_r     <= CHUNK_FLAG;
      held_r      <= '0;
      have_r      <= 1'b0;
      last_r      <= 1'b0;
      wpos_r      <= START_POS;
      rem_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flag_r      <= flag_nxt;
      chunk_r     <= chunk_nxt;
      held_r      <= held_nxt;
      have_r      <= have_nxt;
      last_r      <= last_nxt;
      wpos_r      <= wpos_nxt;
      rem_r       <= rem_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lit_r     <= lit_nxt;
    rpos_r    <= rpos_nxt;
    out_row_r <= out_row_nxt;
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;

  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> ($past(state_r) == S_RD || $past(state_r) == S_WR))
    else $error("copy write without a preceding window read");

  a_copy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (rem_r != '0))
    else $error("window read issued with nothing left to copy");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_END && out_free) |=> (count_r == '0 && wpos_r == START_POS))
    else $error("stream end did not restore stream state");

endmodule

// ===== hw/rtl/lzss_ring_window_decoder_unit.sv =====
// lzss_ring_window_decoder_unit: top level, configuration registers and instances
// depends on lzrw_pkg, lzrw_window and lzrw_ctrl
`timescale 1ns / 1ps

// lzss decoder with a 4 KiB ring window (zero-filled, first write at 0xfee).
// one compressed byte per input request; a flag byte governs the next eight
// chunks from bit 0, a set bit is a literal, a clear bit a two-byte
// back-reference (12-bit position, length low nibble plus 3). output stops
// once expected_size bytes have been produced; later input is swallowed.
// a request with in_tlast closes the stream with one result that has
// byte_valid low, stream_end high and the byte count, then the window and
// parser restart. a flag byte or first reference byte is taken in the idle
// state; a literal, each copied byte (a read of the single-port window memory
// then its write-back) and the closing result go out from their own states,
// which output backpressure can stall. the window needs no clearing pass after
// reset or between streams: a fill count marks which entries of the current
// stream were written, and any other entry reads as zero. expected_size is
// written only while idle: a rule for the user, not enforced by the block.

module lzss_ring_window_decoder_unit
  import lzrw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] in_byte
  input  logic                  in_tlast,    // in_last
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,   // [7:0] out_byte, [31:8] bytes_out
  output logic [1:0]            out_tuser,   // [0] byte_valid, [1] stream_end
  output logic                  out_tlast,   // run_last
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [EXP_W-1:0] exp_size_r;
  logic [EXP_W-1:0] exp_size_nxt;
  logic             cfg_wr;
  logic             cfg_hit;
  win_req_t         win_req;
  logic [7:0]       win_rd_data;
  out_row_t         out_row;

  // single register at byte address 0; word address is paddr above bit 1
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_EXPECTED_SIZE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;

  assign exp_size_nxt = cfg_wr ? cfg_pwdata[EXP_W-1:0] : exp_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_size_r <= '0;
    end else begin
      exp_size_r <= exp_size_nxt;
    end
  end

  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(exp_size_r) : '0;

  // history ring
  lzrw_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (win_req),
    .rd_data (win_rd_data)
  );

  // parser, copy sequencer and output register
  lzrw_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .expected_size (exp_size_r),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_byte       (in_tdata),
    .in_last       (in_tlast),
    .out_valid     (out_tvalid),
    .out_tready    (out_tready),
    .out_row       (out_row),
    .win_req       (win_req),
    .win_rd_data   (win_rd_data)
  );

  assign out_tdata = {out_row.bytes_out, out_row.out_byte};
  assign out_tuser = {out_row.stream_end, out_row.byte_valid};
  assign out_tlast = out_row.run_last;

endmodule

// ===== test/tb.sv =====
// tb: self-checking testbench for lzss_ring_window_decoder_unit, a streaming lzss decoder
// depends on lzrw_pkg and the rtl under hw/rtl; predicts every result in-line and checks it
`timescale 1ns / 1ps

module tb
  import lzrw_pkg::*;
();

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;     // longest item: a back-reference of 18 bytes plus the closing result

  // one compressed byte as it goes onto the input stream
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } comp_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;    // [7:0] in_byte
  logic                  in_tlast = 1'b0;  // in_last
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;        // [7:0] out_byte, [31:8] bytes_out
  logic [1:0]            out_tuser;        // [0] byte_valid, [1] stream_end
  logic                  out_tlast;        // run_last
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lzss_ring_window_decoder_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // compressed bytes waiting to be sent, and decoded rows waiting to arrive
  comp_byte_t comp_stream[$];
  out_row_t   decoded_rows[$];
  int         errors = 0;

  // ---------------------------------------------------------------------------
  // decoder mirror: ring window, parser state and the size register
  // ---------------------------------------------------------------------------
  logic [7:0]       ring_mirror [WINDOW_SIZE];
  logic [POS_W-1:0] ring_wr_pos;
  logic [7:0]       flag_reg;
  logic [3:0]       chunk_cnt;
  logic [7:0]       ref_low_byte;
  logic             ref_pending;
  logic [23:0]      byte_count;
  logic [23:0]      size_limit = '0;    // expected_size, zero out of reset

  // rows produced by the request being decoded
  out_row_t step_rows[$];

  task automatic restart_mirror();
    foreach (ring_mirror[i]) ring_mirror[i] = 8'h00;
    ring_wr_pos  = START_POS;
    flag_reg     = '0;
    chunk_cnt    = CHUNK_FLAG;
    ref_low_byte = '0;
    ref_pending  = 1'b0;
    byte_count   = '0;
  endtask

  // every decoded byte goes back into the ring and out as one row
  task automatic emit_decoded(input logic [7:0] v);
    ring_mirror[ring_wr_pos] = v;
    ring_wr_pos = ring_wr_pos + 1'b1;
    byte_count  = byte_count + 1'b1;
    step_rows.push_back('{byte_valid: 1'b1, out_byte: v, run_last: 1'b0,
                          stream_end: 1'b0, bytes_out: byte_count});
  endtask

  task automatic decode_request(input logic [7:0] b, input logic last);
    logic [POS_W-1:0] src;
    int               copy_len;
    int               k;
    step_rows.delete();
    // once the size is reached the parser swallows everything but the close
    if (byte_count < size_limit) begin
      if (chunk_cnt >= CHUNK_FLAG) begin
        flag_reg  = b;
        chunk_cnt = '0;
      end else if (flag_reg[chunk_cnt[2:0]]) begin
        emit_decoded(b);
        chunk_cnt = chunk_cnt + 1'b1;
      end else if (!ref_pending) begin
        ref_low_byte = b;
        ref_pending  = 1'b1;
      end else begin
        // second reference byte: high nibble extends the position, low nibble the length
        src         = {b[7:4], ref_low_byte};
        copy_len    = int'(b[3:0]) + int'(LEN_BIAS);
        ref_pending = 1'b0;
        chunk_cnt   = chunk_cnt + 1'b1;
        // byte by byte, so an overlapping copy repeats what it just wrote
        for (k = 0; k < copy_len && byte_count < size_limit; k++) begin
          emit_decoded(ring_mirror[src]);
          src = src + 1'b1;
        end
      end
    end
    if (last) begin
      step_rows.push_back('{byte_valid: 1'b0, out_byte: 8'h00, run_last: 1'b0,
                            stream_end: 1'b1, bytes_out: byte_count});
      restart_mirror();
    end
    if (step_rows.size() != 0) step_rows[step_rows.size() - 1].run_last = 1'b1;
    foreach (step_rows[i]) decoded_rows.push_back(step_rows[i]);
  endtask

  initial restart_mirror();

  // ---------------------------------------------------------------------------
  // input driver: one compressed byte per request, random gaps in runs
  // ---------------------------------------------------------------------------
  int unsigned in_gap = 0;
  int unsigned in_run = 0;
  bit          in_quiet = 1'b0;

  always @(posedge clk) begin
    comp_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      // the mirror decodes each request at the edge the block takes it
      if (in_tvalid && in_tready) decode_request(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (comp_stream.size() != 0) begin
          nxt = comp_stream.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tlast  <= nxt.last;
          // gap before the following request; some runs go back to back
          if (in_run == 0) begin
            in_quiet = ($urandom_range(0, 2) == 0);
            in_run   = $urandom_range(8, 40);
          end
          in_run--;
          in_gap = in_quiet ? 0 : $urandom_range(0, 11);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: random stalls, each result checked against the oldest row
  // ---------------------------------------------------------------------------
  int unsigned out_stall = 0;
  int unsigned out_run = 0;
  bit          out_quiet = 1'b0;

  always @(posedge clk) begin
    out_row_t got;
    out_row_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{byte_valid: out_tuser[0], out_byte: out_tdata[7:0], run_last: out_tlast,
                stream_end: out_tuser[1], bytes_out: out_tdata[31:8]};
        if (decoded_rows.size() == 0) begin
          $display("%0t: result with nothing pending: valid=%0d byte=%02h last=%0d end=%0d count=%0d",
                   $time, got.byte_valid, got.out_byte, got.run_last, got.stream_end,
                   got.bytes_out);
          errors++;
        end else begin
          want = decoded_rows.pop_front();
          if (got.byte_valid !== want.byte_valid || got.out_byte !== want.out_byte ||
              got.run_last !== want.run_last || got.stream_end !== want.stream_end ||
              got.bytes_out !== want.bytes_out) begin
            $display("%0t: mismatch, expected valid=%0d byte=%02h last=%0d end=%0d count=%0d",
                     $time, want.byte_valid, want.out_byte, want.run_last, want.stream_end,
                     want.bytes_out);
            $display("%0t: mismatch, actual   valid=%0d byte=%02h last=%0d end=%0d count=%0d",
                     $time, got.byte_valid, got.out_byte, got.run_last, got.stream_end,
                     got.bytes_out);
            errors++;
          end
        end
        if (out_run == 0) begin
          out_quiet = ($urandom_range(0, 2) == 0);
          out_run   = $urandom_range(8, 40);
        end
        out_run--;
        out_stall = out_quiet ? 0 : $urandom_range(0, 11);
      end
      if (out_stall != 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // hard stop in case the block hangs
  int unsigned cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("lzss_ring_window_decoder_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] d, input logic last);
    comp_stream.push_back('{data: d, last: last});
  endtask

  // apb write of expected_size: setup cycle, then access cycle
  task automatic write_expected_size(input logic [23:0] v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * int'(REG_EXPECTED_SIZE));
    cfg_pwdata  <= CFG_DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    // register captured at this edge
    size_limit = v;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // block idle: everything sent, every row back, and time for a silent item to finish
  task automatic wait_idle();
    @(negedge clk);
    while (comp_stream.size() != 0 || in_tvalid || decoded_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // well-formed stream with random content; references mostly land just behind the
  // write position so overlaps and real history get hit, the rest anywhere in the ring
  task automatic queue_random_stream(input int n_chunks, input bit close, input bit cut);
    comp_byte_t       items[$];
    logic [7:0]       flags;
    logic [7:0]       b1;
    logic [POS_W-1:0] est_pos;
    logic [POS_W-1:0] src;
    int               c;
    int               keep;
    est_pos = START_POS;
    flags   = '0;
    for (c = 0; c < n_chunks; c++) begin
      if (c % 8 == 0) begin
        flags = 8'($urandom);
        items.push_back('{data: flags, last: 1'b0});
      end
      if (flags[c % 8]) begin
        items.push_back('{data: 8'($urandom), last: 1'b0});
        est_pos = est_pos + 1'b1;
      end else begin
        b1 = 8'($urandom);
        if ($urandom_range(0, 2) != 0) src = est_pos - POS_W'($urandom_range(1, 24));
        else src = POS_W'($urandom);
        items.push_back('{data: src[7:0], last: 1'b0});
        items.push_back('{data: {src[11:8], b1[3:0]}, last: 1'b0});
        est_pos = est_pos + POS_W'(int'(b1[3:0]) + 3);
      end
    end
    // broken stream: closed anywhere, even between the two reference bytes
    if (cut && items.size() > 1) begin
      keep = $urandom_range(1, items.size());
      while (items.size() > keep) void'(items.pop_back());
    end
    if (close) begin
      if (items.size() == 0) items.push_back('{data: 8'($urandom), last: 1'b0});
      items[items.size() - 1].last = 1'b1;
    end
    foreach (items[i]) comp_stream.push_back(items[i]);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [23:0] phase_sizes[5];
    int          p;
    int          queued;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // size zero out of reset: everything swallowed, only the close shows up
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);
    wait_idle();

    write_expected_size(24'hFFFFFF);
    // alternating literals and references
    push_byte(8'h55, 1'b0);
    push_byte(8'h00, 1'b0);                           // literal zero
    push_byte(8'hEE, 1'b0); push_byte(8'hF0, 1'b0);   // at the start position, overlapping
    push_byte(8'hFF, 1'b0);                           // literal all ones
    push_byte(8'h00, 1'b0); push_byte(8'h0F, 1'b0);   // longest copy, write wraps past 0xfff
    push_byte(8'hA5, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hF5, 1'b0);   // read wraps from 0xfff to 0
    push_byte(8'h5A, 1'b0);
    push_byte(8'h12, 1'b0); push_byte(8'h3A, 1'b0);
    // all-reference flag, then the stream closes on a lone first byte: dropped
    push_byte(8'h00, 1'b0);
    push_byte(8'h34, 1'b1);
    // stream closed on a literal, then one closed on its flag byte
    push_byte(8'h01, 1'b0);
    push_byte(8'h77, 1'b1);
    push_byte(8'hFF, 1'b1);
    wait_idle();

    // copy cut short by the size, trailing bytes swallowed
    write_expected_size(24'd5);
    push_byte(8'h00, 1'b0);
    push_byte(8'hEE, 1'b0); push_byte(8'h0F, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b1);
    wait_idle();

    // random phases; the third leaves its stream open so the next size
    // change lands in the middle of a stream
    phase_sizes[0] = 24'hFFFFFF;
    phase_sizes[1] = 24'($urandom_range(1, 48));
    phase_sizes[2] = 24'($urandom_range(40, 400));
    phase_sizes[3] = 24'd1;
    phase_sizes[4] = 24'($urandom);
    for (p = 0; p < 5; p++) begin
      write_expected_size(phase_sizes[p]);
      queued = 0;
      while (queued < 24) begin
        queue_random_stream($urandom_range(1, 30),
                            !(p == 2 && queued >= 16), $urandom_range(0, 4) == 0);
        queued = comp_stream.size();
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("lzss_ring_window_decoder_unit regression: pass");
    end else begin
      $display("lzss_ring_window_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule
